### rtl/lmsw_pkg.sv
`default_nettype none
package lmsw_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int NUM_ELEMENTS_DEF = 16;

    localparam int STORE_DEPTH = 16;
    localparam int STORE_AW    = 4;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 56;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [15:0] LEARN_RATE_RST = 16'd16;
    localparam logic [4:0]  ELEM_COUNT_RST = 5'd16;
    localparam logic        COPY_BACK_RST  = 1'b0;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_ELEM = 2'd1;
    localparam logic [1:0] KIND_OFF  = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_BACK  = 2'd2;

    localparam logic RES_ERROR  = 1'b0;
    localparam logic RES_WEIGHT = 1'b1;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'h0001,
        S_IDLE     = 14'h0002,
        S_P1_RD    = 14'h0004,
        S_P1_MUL   = 14'h0008,
        S_P1_ACC   = 14'h0010,
        S_ERR      = 14'h0020,
        S_P2_RD    = 14'h0040,
        S_P2_MUL1  = 14'h0080,
        S_P2_MUL2  = 14'h0100,
        S_P2_MUL3  = 14'h0200,
        S_P2_WR    = 14'h0400,
        S_EMIT_ERR = 14'h0800,
        S_RO_RD    = 14'h1000,
        S_RO_EMIT  = 14'h2000
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < 64'shFFFF_FFFF_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/lmsw_ram.sv
`default_nettype none
module lmsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/lms_weight_adaptation.sv
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid / in_stall    kind, channel, index, value, target, intercept
// out      out_valid / out_stall  result_type, error_value, weight_index,
//                                 weight_value, last_of_run
// cfg      cfg_we                 cfg_index, cfg_data
//
// Loads, non-final elements and plain feedback-off words stay in S_IDLE. A final
// element runs S_P1_RD/MUL/ACC per element in use to accumulate, S_ERR, then
// S_P2_RD/MUL1/MUL2/MUL3/WR per element to update, all on one 32x32 multiplier,
// then S_EMIT_ERR. A weight readout runs S_RO_RD, S_RO_EMIT per weight, paced by
// the weight RAM read. After reset a clearing pass zeroes the weight RAM; in_stall
// stays high until it ends. Output stall holds only the sequencer steps that emit
// a word; an emitted word waits in the output register.
module lms_weight_adaptation
    import lmsw_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           kind,
    input  wire logic [1:0]           channel,
    input  wire logic [3:0]           index,
    input  wire logic signed [31:0]   value,
    input  wire logic signed [7:0]    target,
    input  wire logic signed [31:0]   intercept,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      result_type,
    output logic signed [31:0]        error_value,
    output logic [3:0]                weight_index,
    output logic signed [31:0]        weight_value,
    output logic                      last_of_run,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int W_DEPTH = NUM_CHANNELS * NUM_ELEMENTS;
    localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CAP     = (STORE_DEPTH < NUM_ELEMENTS) ? STORE_DEPTH : NUM_ELEMENTS;

    state_t                     state_reg, state_next;
    logic [STORE_AW-1:0]        i_reg, i_next;
    logic [W_AW-1:0]            clr_reg, clr_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [DATA_W-1:0]   err_reg, err_next;
    logic signed [63:0]         prod_reg, prod_next;
    logic [23:0]                tlo_reg, tlo_next;
    logic signed [39:0]         hi_reg, hi_next;
    logic [CH_W-1:0]            ch_reg, ch_next;
    logic signed [7:0]          tgt_reg, tgt_next;
    logic signed [DATA_W-1:0]   icpt_reg, icpt_next;
    logic [NUM_CHANNELS-1:0]    loaded_reg, loaded_next;
    logic [NUM_CHANNELS-1:0]    prev_fb_reg, prev_fb_next;
    logic signed [DATA_W-1:0]   mean_reg [NUM_CHANNELS];
    logic signed [DATA_W-1:0]   mean_next [NUM_CHANNELS];
    logic [15:0]                learn_rate_reg, learn_rate_next;
    logic [4:0]                 elem_count_reg, elem_count_next;
    logic                       copy_back_reg, copy_back_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_type_reg, out_type_next;
    logic signed [DATA_W-1:0]   out_err_reg, out_err_next;
    logic [3:0]                 out_widx_reg, out_widx_next;
    logic signed [DATA_W-1:0]   out_wval_reg, out_wval_next;
    logic                       out_last_reg, out_last_next;

    logic                       w_we;
    logic [W_AW-1:0]            w_waddr;
    logic [W_AW-1:0]            w_raddr;
    logic signed [DATA_W-1:0]   w_wdata;
    logic signed [DATA_W-1:0]   w_rdata;
    logic                       e_we;
    logic signed [DATA_W-1:0]   e_rdata;

    logic signed [DATA_W-1:0]   mul_a, mul_b;
    logic signed [63:0]         mul_p;

    logic                       accept;
    logic                       ch_ok;
    logic [CH_W-1:0]            ch_idx;
    logic [W_AW-1:0]            wa_load;
    logic [4:0]                 n_eff;
    logic [STORE_AW-1:0]        n_last;
    logic                       at_last;
    logic                       out_free;
    logic signed [47:0]         upd;
    logic signed [63:0]         w_sum;
    logic signed [DATA_W-1:0]   w_new;
    logic signed [ACC_W-1:0]    tgt_q;
    logic signed [ACC_W-1:0]    pred;

    lmsw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (W_DEPTH)
    ) u_weights (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    lmsw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_elements (
        .clk   (clk),
        .we    (e_we),
        .waddr (index),
        .wdata (value),
        .raddr (i_reg),
        .rdata (e_rdata)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && !in_stall;
    assign ch_ok        = int'(channel) < NUM_CHANNELS;
    assign ch_idx       = CH_W'(channel);
    assign wa_load      = W_AW'(int'(channel) * NUM_ELEMENTS + int'(index));
    assign w_raddr      = W_AW'(int'(ch_reg) * NUM_ELEMENTS + int'(i_reg));
    assign out_free     = !out_valid_reg || !out_stall;

    // clamp element count into 1..CAP
    always_comb
    begin
        if (elem_count_reg == 5'd0)
        begin
            n_eff = 5'd1;
        end
        else if (int'(elem_count_reg) > CAP)
        begin
            n_eff = 5'(CAP);
        end
        else
        begin
            n_eff = elem_count_reg;
        end
    end
    assign n_last  = STORE_AW'(n_eff - 5'd1);
    assign at_last = (i_reg == n_last);

    assign mul_p = mul_a * mul_b;

    // update = floor(t * rate / 2^16) from the high and low partial products
    assign upd   = $signed({hi_reg, 8'b0}) + $signed({24'b0, prod_reg[39:16]});
    assign w_sum = 64'(w_rdata) + 64'(upd);
    assign w_new = sat32(w_sum);

    assign tgt_q = {{(ACC_W-24){tgt_reg[7]}}, tgt_reg, 16'b0};
    assign pred  = acc_reg - ACC_W'(mean_reg[ch_reg]);

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        clr_next        = clr_reg;
        acc_next        = acc_reg;
        err_next        = err_reg;
        prod_next       = prod_reg;
        tlo_next        = tlo_reg;
        hi_next         = hi_reg;
        ch_next         = ch_reg;
        tgt_next        = tgt_reg;
        icpt_next       = icpt_reg;
        loaded_next     = loaded_reg;
        prev_fb_next    = prev_fb_reg;
        mean_next       = mean_reg;
        learn_rate_next = learn_rate_reg;
        elem_count_next = elem_count_reg;
        copy_back_next  = copy_back_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_type_next   = out_type_reg;
        out_err_next    = out_err_reg;
        out_widx_next   = out_widx_reg;
        out_wval_next   = out_wval_reg;
        out_last_next   = out_last_reg;

        w_we    = 1'b0;
        w_waddr = w_raddr;
        w_wdata = w_new;
        e_we    = 1'b0;
        mul_a   = w_rdata;
        mul_b   = e_rdata;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEARN_RATE: learn_rate_next = cfg_data;
                REG_ELEM_COUNT: elem_count_next = cfg_data[4:0];
                REG_COPY_BACK:  copy_back_next  = cfg_data[0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                w_we     = 1'b1;
                w_waddr  = clr_reg;
                w_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (int'(clr_reg) == W_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept && ch_ok && kind != KIND_BAD)
                begin
                    ch_next   = ch_idx;
                    tgt_next  = target;
                    icpt_next = intercept;
                    i_next    = '0;
                    acc_next  = '0;
                    unique case (kind)
                        KIND_LOAD:
                        begin
                            if (!loaded_reg[ch_idx] && int'(index) < NUM_ELEMENTS)
                            begin
                                w_we    = 1'b1;
                                w_waddr = wa_load;
                                w_wdata = value;
                            end
                        end
                        KIND_ELEM:
                        begin
                            loaded_next[ch_idx]  = 1'b1;
                            prev_fb_next[ch_idx] = 1'b1;
                            e_we                 = 1'b1;
                            if (index == n_last)
                            begin
                                state_next = S_P1_RD;
                            end
                        end
                        default:
                        begin
                            loaded_next[ch_idx]  = 1'b1;
                            prev_fb_next[ch_idx] = 1'b0;
                            if (prev_fb_reg[ch_idx] && copy_back_reg)
                            begin
                                state_next = S_RO_RD;
                            end
                        end
                    endcase
                end
            end

            S_P1_RD:
            begin
                state_next = S_P1_MUL;
            end

            S_P1_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_P1_ACC;
            end

            S_P1_ACC:
            begin
                acc_next = acc_reg + ACC_W'($signed(prod_reg[63:16]));
                if (at_last)
                begin
                    i_next     = '0;
                    state_next = S_ERR;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_P1_RD;
                end
            end

            S_ERR:
            begin
                err_next   = sat32(64'(tgt_q - pred));
                state_next = S_P2_RD;
            end

            S_P2_RD:
            begin
                state_next = S_P2_MUL1;
            end

            S_P2_MUL1:
            begin
                mul_a      = e_rdata;
                mul_b      = err_reg;
                prod_next  = mul_p;
                state_next = S_P2_MUL2;
            end

            S_P2_MUL2:
            begin
                // split t = floor(e*err/2^16) into a signed high and unsigned low part
                mul_a      = 32'($signed(prod_reg[63:40]));
                mul_b      = $signed({16'b0, learn_rate_reg});
                prod_next  = mul_p;
                tlo_next   = prod_reg[39:16];
                state_next = S_P2_MUL3;
            end

            S_P2_MUL3:
            begin
                mul_a      = $signed({8'b0, tlo_reg});
                mul_b      = $signed({16'b0, learn_rate_reg});
                prod_next  = mul_p;
                hi_next    = prod_reg[39:0];
                state_next = S_P2_WR;
            end

            S_P2_WR:
            begin
                w_we = 1'b1;
                if (at_last)
                begin
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        if ((c == 1 || c == 2) && ch_reg == CH_W'(c))
                        begin
                            mean_next[c] = icpt_reg;
                        end
                    end
                    state_next = S_EMIT_ERR;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_P2_RD;
                end
            end

            S_EMIT_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_type_next  = RES_ERROR;
                    out_err_next   = err_reg;
                    out_widx_next  = '0;
                    out_wval_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_RO_RD:
            begin
                state_next = S_RO_EMIT;
            end

            S_RO_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_type_next  = RES_WEIGHT;
                    out_err_next   = '0;
                    out_widx_next  = i_reg;
                    out_wval_next  = w_rdata;
                    out_last_next  = at_last;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RO_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            i_reg          <= '0;
            clr_reg        <= '0;
            loaded_reg     <= '0;
            prev_fb_reg    <= '0;
            learn_rate_reg <= LEARN_RATE_RST;
            elem_count_reg <= ELEM_COUNT_RST;
            copy_back_reg  <= COPY_BACK_RST;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                mean_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            clr_reg        <= clr_next;
            loaded_reg     <= loaded_next;
            prev_fb_reg    <= prev_fb_next;
            learn_rate_reg <= learn_rate_next;
            elem_count_reg <= elem_count_next;
            copy_back_reg  <= copy_back_next;
            out_valid_reg  <= out_valid_next;
            mean_reg       <= mean_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        err_reg      <= err_next;
        prod_reg     <= prod_next;
        tlo_reg      <= tlo_next;
        hi_reg       <= hi_next;
        ch_reg       <= ch_next;
        tgt_reg      <= tgt_next;
        icpt_reg     <= icpt_next;
        out_type_reg <= out_type_next;
        out_err_reg  <= out_err_next;
        out_widx_reg <= out_widx_next;
        out_wval_reg <= out_wval_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_type  = out_type_reg;
    assign error_value  = out_err_reg;
    assign weight_index = out_widx_reg;
    assign weight_value = out_wval_reg;
    assign last_of_run  = out_last_reg;

endmodule
`default_nettype wire

### dv/tb_lms_weight_adaptation.sv
module tb_lms_weight_adaptation;
    timeunit 1ns;
    timeprecision 1ps;
    import lmsw_pkg::*;

    localparam int N_CH   = NUM_CHANNELS_DEF;
    localparam int N_ELEM = NUM_ELEMENTS_DEF;
    localparam int N_CAP  = (STORE_DEPTH < N_ELEM) ? STORE_DEPTH : N_ELEM;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic [1:0]         kind;
        logic [1:0]         chan;
        logic [3:0]         idx;
        logic signed [31:0] value;
        logic signed [7:0]  target;
        logic signed [31:0] icpt;
    } lms_word_t;

    typedef struct {
        logic               rtype;
        logic signed [31:0] err;
        logic [3:0]         widx;
        logic signed [31:0] wval;
        logic               last;
    } lms_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind = '0;
    logic [1:0]            channel = '0;
    logic [3:0]            index = '0;
    logic signed [31:0]    value = '0;
    logic signed [7:0]     target = '0;
    logic signed [31:0]    intercept = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  result_type;
    logic signed [31:0]    error_value;
    logic [3:0]            weight_index;
    logic signed [31:0]    weight_value;
    logic                  last_of_run;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // predictor copy of the block's registers and state
    logic [15:0]           rate_q16 = LEARN_RATE_RST;
    logic [4:0]            elem_count = ELEM_COUNT_RST;
    logic                  copy_back = COPY_BACK_RST;
    logic signed [31:0]    coef [N_CH*N_ELEM];
    logic signed [31:0]    elem_buf [STORE_DEPTH];
    logic signed [31:0]    ch_mean [N_CH];
    logic                  ch_loaded [N_CH];
    logic                  fb_seen [N_CH];

    lms_word_t             word_backlog [$];
    lms_result_t           pending_results [$];
    logic                  in_took = 1'b0;
    int                    words_queued = 0;
    int                    words_accepted = 0;
    int                    mismatch_count = 0;
    int                    sender_idle_pct = 0;
    int                    receiver_stall_pct = 0;
    int                    hold_requests = 0;
    int                    hold_served = 0;
    int                    hold_left = 0;
    logic [15:0]           stored_mask = '0;

    lms_weight_adaptation i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .channel      (channel),
        .index        (index),
        .value        (value),
        .target       (target),
        .intercept    (intercept),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_type  (result_type),
        .error_value  (error_value),
        .weight_index (weight_index),
        .weight_value (weight_value),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic signed [31:0] clip32(input longint x);
        if (x > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (x < -64'sh8000_0000)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic int active_n();
        int n;
        n = int'(elem_count);
        if (n < 1)
            n = 1;
        if (n > N_CAP)
            n = N_CAP;
        return n;
    endfunction

    // Update the state for one accepted word and queue the results it causes.
    task automatic adapt_and_predict(input lms_word_t w);
        int          n;
        int          base;
        int          i;
        longint      acc;
        longint      prod;
        longint      step;
        logic signed [31:0] err;
        lms_result_t r;
        n = active_n();
        if (int'(w.chan) >= N_CH || w.kind == KIND_BAD)
            return;
        base = int'(w.chan) * N_ELEM;
        if (w.kind == KIND_LOAD)
        begin
            if (!ch_loaded[w.chan] && int'(w.idx) < N_ELEM)
                coef[base + int'(w.idx)] = w.value;
            return;
        end
        ch_loaded[w.chan] = 1'b1;
        if (w.kind == KIND_ELEM)
        begin
            fb_seen[w.chan] = 1'b1;
            elem_buf[w.idx] = w.value;
            if (int'(w.idx) != n - 1)
                return;
            acc = 0;
            for (i = 0; i < n; i++)
                acc += (longint'(coef[base + i]) * longint'(elem_buf[i])) >>> 16;
            acc -= longint'(ch_mean[w.chan]);
            err = clip32(longint'(w.target) * 65536 - acc);
            for (i = 0; i < n; i++)
            begin
                prod = (longint'(elem_buf[i]) * longint'(err)) >>> 16;
                step = (prod * longint'(rate_q16)) >>> 16;
                coef[base + i] = clip32(longint'(coef[base + i]) + step);
            end
            if (w.chan == 2'd1 || w.chan == 2'd2)
                ch_mean[w.chan] = w.icpt;
            r = '{RES_ERROR, err, 4'd0, 32'sd0, 1'b1};
            pending_results.push_back(r);
            return;
        end
        // feedback off
        if (fb_seen[w.chan] && copy_back)
        begin
            for (i = 0; i < n; i++)
            begin
                r = '{RES_WEIGHT, 32'sd0, 4'(i), coef[base + i], (i == n - 1)};
                pending_results.push_back(r);
            end
        end
        fb_seen[w.chan] = 1'b0;
    endtask

    // Track accepted words, check accepted results.
    always @(posedge clk)
    begin : track
        lms_word_t   seen;
        lms_result_t e;
        int          i;
        if (!rst_n)
        begin
            in_took <= 1'b0;
            for (i = 0; i < N_CH * N_ELEM; i++)
                coef[i] = '0;
            for (i = 0; i < STORE_DEPTH; i++)
                elem_buf[i] = '0;
            for (i = 0; i < N_CH; i++)
            begin
                ch_mean[i] = '0;
                ch_loaded[i] = 1'b0;
                fb_seen[i] = 1'b0;
            end
        end
        else
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                seen = '{kind, channel, index, value, target, intercept};
                adapt_and_predict(seen);
                words_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: type %0d err %h idx %0d w %h last %0d",
                                 result_type, error_value, weight_index, weight_value,
                                 last_of_run);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (result_type !== e.rtype || error_value !== e.err ||
                        weight_index !== e.widx || weight_value !== e.wval ||
                        last_of_run !== e.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result mismatch: exp type %0d err %h idx %0d w %h last %0d",
                                      " / got type %0d err %h idx %0d w %h last %0d"},
                                     e.rtype, e.err, e.widx, e.wval, e.last,
                                     result_type, error_value, weight_index, weight_value,
                                     last_of_run);
                    end
                end
            end
        end
    end

    // Input driver: hold the word until taken, then advance or idle.
    always @(negedge clk)
    begin : drive
        lms_word_t w;
        if (!in_valid || in_took)
        begin
            if (word_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                w = word_backlog.pop_front();
                in_valid  <= 1'b1;
                kind      <= w.kind;
                channel   <= w.chan;
                index     <= w.idx;
                value     <= w.value;
                target    <= w.target;
                intercept <= w.icpt;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random, or a long hold-off on request.
    always @(negedge clk)
    begin : backpressure
        if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    function automatic logic [31:0] pick_q16();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(524288)) - 32'd262144;
        endcase
    endfunction

    task automatic push_word(input logic [1:0] k, input logic [1:0] ch,
                             input logic [3:0] idx, input logic [31:0] v,
                             input logic [7:0] t, input logic [31:0] ic);
        lms_word_t w;
        w = '{k, ch, idx, v, t, ic};
        if (k == KIND_ELEM)
            stored_mask[idx] = 1'b1;
        word_backlog.push_back(w);
        words_queued++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_LEARN_RATE: rate_q16 = data;
            REG_ELEM_COUNT: elem_count = data[4:0];
            REG_COPY_BACK:  copy_back = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every word to be taken and every result to arrive, then let
    // any silent work finish.
    task automatic settle();
        while (words_accepted != words_queued || pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly whole feedback vectors with random content; the rest is noise.
    task automatic add_random_burst(inout int made);
        int          n;
        int          pick;
        int          k;
        int          i;
        logic [1:0]  ch;
        logic [3:0]  idx;
        logic [16:0] need;
        n = active_n();
        pick = $urandom_range(99);
        ch = 2'($urandom_range(3));
        if (pick < 60 || (pick < 68 && n == 1))
        begin
            for (i = 0; i < n; i++)
                push_word(KIND_ELEM, ch, 4'(i), pick_q16(), 8'($urandom), pick_q16());
            made += n;
            if ($urandom_range(1))
            begin
                push_word(KIND_OFF, ch, 4'($urandom), pick_q16(), 8'($urandom), pick_q16());
                made++;
            end
        end
        else if (pick < 68)
        begin
            // broken vector: stop short of the last element
            k = $urandom_range(n - 2);
            for (i = 0; i <= k; i++)
                push_word(KIND_ELEM, ch, 4'(i), pick_q16(), 8'($urandom), pick_q16());
            made += k + 1;
        end
        else if (pick < 76)
        begin
            push_word(KIND_LOAD, ch, 4'($urandom), pick_q16(), 8'($urandom), pick_q16());
            made++;
        end
        else if (pick < 82)
        begin
            push_word(KIND_BAD, ch, 4'($urandom), pick_q16(), 8'($urandom), pick_q16());
            made++;
        end
        else if (pick < 90)
        begin
            push_word(KIND_OFF, ch, 4'($urandom), pick_q16(), 8'($urandom), pick_q16());
            made++;
        end
        else
        begin
            idx = 4'($urandom);
            need = (17'd1 << n) - 17'd1;
            // never fire a prediction over an element slot not yet written
            if (int'(idx) == n - 1 && (({1'b0, stored_mask} & need) != need))
                idx = 4'(n);
            push_word(KIND_ELEM, ch, idx, pick_q16(), 8'($urandom), pick_q16());
            made++;
        end
    endtask

    task automatic run_phase(input logic [15:0] lr, input logic [15:0] ec, input logic cb,
                             input int send_pct, input int stall_pct, input int items,
                             input bit hold);
        int made;
        set_reg(REG_LEARN_RATE, lr);
        set_reg(REG_ELEM_COUNT, ec);
        set_reg(REG_COPY_BACK, {15'($urandom), cb});
        @(posedge clk);
        sender_idle_pct = send_pct;
        receiver_stall_pct = stall_pct;
        if (hold)
            hold_requests++;
        made = 0;
        while (made < items)
            add_random_burst(made);
        settle();
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // hold off until the weight clearing pass is over
        while (in_stall)
            @(negedge clk);

        set_reg(REG_LEARN_RATE, 16'hFFFF);
        set_reg(REG_ELEM_COUNT, 16'd3);
        set_reg(REG_COPY_BACK, 16'd1);
        @(posedge clk);
        push_word(KIND_LOAD, 2'd0, 4'd0,  32'h7FFF_FFFF, 8'd0, 32'd0);
        push_word(KIND_LOAD, 2'd0, 4'd1,  32'h8000_0000, 8'd0, 32'd0);
        push_word(KIND_LOAD, 2'd0, 4'd15, 32'h1234_5678, 8'd0, 32'd0);
        push_word(KIND_LOAD, 2'd1, 4'd0,  32'h0001_0000, 8'd0, 32'd0);
        push_word(KIND_LOAD, 2'd1, 4'd2,  32'hFFFF_0000, 8'd0, 32'd0);
        push_word(KIND_BAD,  2'd0, 4'd15, 32'hFFFF_FFFF, 8'h7F, 32'h7FFF_FFFF);
        // feedback off with no feedback before: silent, but marks the channel used
        push_word(KIND_OFF,  2'd3, 4'd0,  32'd0, 8'd0, 32'd0);
        push_word(KIND_LOAD, 2'd3, 4'd0,  32'h0005_0000, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd0, 4'd0,  32'h7FFF_FFFF, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd0, 4'd1,  32'h8000_0000, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd0, 4'd2,  32'h7FFF_FFFF, 8'sd127, 32'h0001_0000);
        push_word(KIND_LOAD, 2'd0, 4'd0,  32'h0003_0000, 8'd0, 32'd0);
        push_word(KIND_OFF,  2'd0, 4'd0,  32'd0, 8'd0, 32'd0);
        push_word(KIND_OFF,  2'd0, 4'd0,  32'd0, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd1, 4'd0,  32'h0002_0000, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd1, 4'd1,  32'hFFFE_8000, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd1, 4'd2,  32'h0000_4000, 8'h80, 32'h8000_0000);
        push_word(KIND_ELEM, 2'd1, 4'd0,  32'h0001_0000, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd1, 4'd1,  32'h0001_0000, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd1, 4'd2,  32'h0001_0000, 8'd0, 32'h7FFF_FFFF);
        push_word(KIND_ELEM, 2'd2, 4'd2,  32'd0, 8'hFF, 32'h0040_0000);
        push_word(KIND_ELEM, 2'd3, 4'd2,  32'h0002_0000, 8'd5, 32'h00AA_0000);
        push_word(KIND_OFF,  2'd1, 4'd7,  32'd0, 8'd0, 32'd0);
        push_word(KIND_ELEM, 2'd0, 4'd15, 32'd0, 8'd0, 32'd0);
        push_word(KIND_OFF,  2'd2, 4'd0,  32'd0, 8'd0, 32'd0);
        settle();

        run_phase(16'd0,           16'd1,     1'b1, 0,  0,  14, 1'b0);
        run_phase(16'd16,          16'd16,    1'b0, 83, 0,  16, 1'b0);
        run_phase(16'hFFFF,        16'd2,     1'b1, 0,  83, 14, 1'b0);
        run_phase(16'($urandom),   16'hFFE4,  1'b1, 9,  9,  14, 1'b0);
        // long receiver hold-off while the sender keeps offering words
        run_phase(16'($urandom),   16'd1,     1'b1, 0,  0,  14, 1'b1);
        set_reg(REG_SPARE, 16'($urandom));
        run_phase(16'($urandom),   16'd0,     1'b1, 83, 83, 10, 1'b0);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
